[sv/bmsc_pkg.sv]
// Shared types, operation codes and helper functions for the bitmap block.
package bmsc_pkg;

    // Operation codes carried on the operation port
    typedef logic [1:0] op_t;
    localparam op_t OP_TEST  = 2'd0;
    localparam op_t OP_SET   = 2'd1;
    localparam op_t OP_CLEAR = 2'd2;

    // Field widths fixed by the interface
    localparam int INDEX_W   = 16;
    localparam int HIGH_W    = 12;
    localparam int MAX_BITS  = 64;
    localparam int MSB_W     = 6;

    // Word index width large enough for the largest word count
    localparam int WIDX_W    = 10;

    // Flags searched per group in the first search stage
    localparam int GROUP_SIZE = 32;
    localparam int GROUP_W    = 5;

    // Divide-by-word-size reciprocal: shift and coefficient width
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 30;

    // Result of the highest nonzero word search
    typedef struct packed {
        logic              found;
        logic [WIDX_W-1:0] word;
    } search_result_t;

    // Position of the highest set bit, 0 when the word is zero
    function automatic logic [MSB_W-1:0] msb64(input logic [MAX_BITS-1:0] w);
        logic [MSB_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < MAX_BITS; i++)
        begin
            if (w[i])
            begin
                pos = MSB_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

[sv/bmsc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module bmsc_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  re,
    input  logic [ADDR_W-1:0]     raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/bmsc_flag_search.sv]
// Two-stage registered search for the highest word whose nonzero flag is set.
module bmsc_flag_search #(
    parameter int NUM_WORDS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [NUM_WORDS-1:0]        flags,
    output bmsc_pkg::search_result_t    result
);

    localparam int NG = (NUM_WORDS + bmsc_pkg::GROUP_SIZE - 1) / bmsc_pkg::GROUP_SIZE;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;
    localparam int PW = NG * bmsc_pkg::GROUP_SIZE;

    logic [PW-1:0]                       padded;
    logic [NG-1:0]                       grp_nz;
    logic [GW-1:0]                       gsel;
    logic [GW-1:0]                       gsel_reg;
    logic                                gany_reg;
    logic [bmsc_pkg::GROUP_SIZE-1:0]     slice;
    logic [bmsc_pkg::GROUP_W-1:0]        bsel;
    logic [GW+bmsc_pkg::GROUP_W-1:0]     wfull;

    assign padded = PW'(flags);

    // Stage one: pick the highest nonempty group
    always_comb
    begin
        gsel = '0;
        for (int g = 0; g < NG; g++)
        begin
            grp_nz[g] = |padded[g*bmsc_pkg::GROUP_SIZE +: bmsc_pkg::GROUP_SIZE];
            if (grp_nz[g])
            begin
                gsel = GW'(g);
            end
        end
    end

    // Stage two: pick the highest flag inside the chosen group
    always_comb
    begin
        slice = padded[gsel_reg*bmsc_pkg::GROUP_SIZE +: bmsc_pkg::GROUP_SIZE];
        bsel  = '0;
        for (int b = 0; b < bmsc_pkg::GROUP_SIZE; b++)
        begin
            if (slice[b])
            begin
                bsel = bmsc_pkg::GROUP_W'(b);
            end
        end
        wfull = {gsel_reg, bsel};
    end

    // Hold the stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsel_reg     <= '0;
            gany_reg     <= 1'b0;
            result.found <= 1'b0;
            result.word  <= '0;
        end
        else
        begin
            gsel_reg     <= gsel;
            gany_reg     <= |grp_nz;
            result.found <= gany_reg;
            result.word  <= bmsc_pkg::WIDX_W'(wfull);
        end
    end

endmodule

[sv/bitmap_set_clear_test_msb.sv]
// Bit store with test/set/clear and tracking of the highest set bit.
// An item runs through divide, address, read-modify-write and output states; an out-of-range
// index skips the read-modify-write, and a clear that empties the top word adds search and
// reread states (no reread when that clear empties the store). Start is taken in the done
// cycle; items are taken one at a time, so a new item waits until the last one is done.
// Reset clears control and flags; words with a clear flag read as zero. No receiver stall.
module bitmap_set_clear_test_msb #(
    parameter int NUM_WORDS = 64,
    parameter int WORD_BITS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      operation,
    input  logic [bmsc_pkg::INDEX_W-1:0]    bit_index,
    output logic                            done,
    output logic                            bit_was_set,
    output logic                            out_of_range,
    output logic [bmsc_pkg::HIGH_W-1:0]     highest_set_index,
    output logic                            any_set
);

    localparam int AW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OW       = $clog2(WORD_BITS);
    localparam int CAPACITY = NUM_WORDS * WORD_BITS;
    localparam logic [bmsc_pkg::RECIP_W-1:0] RECIP = bmsc_pkg::RECIP_W'(
        ((64'd1 << bmsc_pkg::RECIP_SHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
    localparam int PROD_W   = bmsc_pkg::INDEX_W + bmsc_pkg::RECIP_W;
    localparam int Q_W      = PROD_W - bmsc_pkg::RECIP_SHIFT;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_ADDR, S_RMW, S_SRCH_A, S_SRCH_B, S_FETCH, S_MSB, S_OUT
    } state_t;

    state_t                          state_reg, state_next;
    bmsc_pkg::op_t                   op_reg, op_next;
    logic [bmsc_pkg::INDEX_W-1:0]    idx_reg, idx_next;
    logic [Q_W-1:0]                  q_reg, q_next;
    logic                            oor_reg, oor_next;
    logic [AW-1:0]                   word_reg, word_next;
    logic [OW-1:0]                   off_reg, off_next;
    logic                            was_reg, was_next;
    logic [NUM_WORDS-1:0]            flags_reg, flags_next;
    logic [AW-1:0]                   top_word_reg, top_word_next;
    logic [OW-1:0]                   top_bit_reg, top_bit_next;
    logic                            any_reg, any_next;
    logic                            done_reg, done_next;
    logic                            was_out_reg, was_out_next;
    logic                            oor_out_reg, oor_out_next;
    logic [bmsc_pkg::HIGH_W-1:0]     high_reg, high_next;
    logic                            any_out_reg, any_out_next;

    logic [PROD_W-1:0]               div_prod;
    logic [19:0]                     q_times_bits;
    logic [19:0]                     rem_full;
    logic [WORD_BITS-1:0]            cur_word;
    logic [WORD_BITS-1:0]            bit_mask;
    logic [WORD_BITS-1:0]            new_word;
    logic [OW-1:0]                   new_msb;
    logic [OW-1:0]                   rd_msb;
    logic [31:0]                     high_full;

    logic                            ram_we;
    logic                            ram_re;
    logic [AW-1:0]                   ram_raddr;
    logic [WORD_BITS-1:0]            ram_rdata;
    bmsc_pkg::search_result_t        search;

    // Word storage
    bmsc_ram #(
        .WIDTH  (WORD_BITS),
        .DEPTH  (NUM_WORDS),
        .ADDR_W (AW)
    ) u_words (
        .clk   (clk),
        .we    (ram_we),
        .waddr (word_reg),
        .wdata (new_word),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Highest nonzero word search over the flags
    bmsc_flag_search #(
        .NUM_WORDS (NUM_WORDS)
    ) u_search (
        .clk    (clk),
        .rst_n  (rst_n),
        .flags  (flags_reg),
        .result (search)
    );

    // Split the index into word and offset by reciprocal multiply
    assign div_prod     = PROD_W'(idx_reg) * PROD_W'(RECIP);
    assign q_times_bits = 20'(q_reg) * 20'(WORD_BITS);
    assign rem_full     = 20'(idx_reg) - q_times_bits;

    // Modify the word just read; words never written read as zero
    assign cur_word = flags_reg[word_reg] ? ram_rdata : '0;
    assign bit_mask = WORD_BITS'(1) << off_reg;
    assign new_msb  = OW'(bmsc_pkg::msb64(bmsc_pkg::MAX_BITS'(new_word)));
    assign rd_msb   = OW'(bmsc_pkg::msb64(bmsc_pkg::MAX_BITS'(ram_rdata)));
    assign high_full = 32'(top_word_reg) * 32'(WORD_BITS) + 32'(top_bit_reg);

    always_comb
    begin
        case (op_reg)
            bmsc_pkg::OP_SET:   new_word = cur_word | bit_mask;
            bmsc_pkg::OP_CLEAR: new_word = cur_word & ~bit_mask;
            default:            new_word = cur_word;
        endcase
    end

    assign ram_we    = (state_reg == S_RMW) &&
                       ((op_reg == bmsc_pkg::OP_SET) || (op_reg == bmsc_pkg::OP_CLEAR));
    assign ram_re    = (state_reg == S_ADDR) || (state_reg == S_FETCH);
    assign ram_raddr = (state_reg == S_FETCH) ? search.word[AW-1:0] : q_reg[AW-1:0];

    // Sequence one item through divide, read-modify-write and top tracking
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        q_next        = q_reg;
        oor_next      = oor_reg;
        word_next     = word_reg;
        off_next      = off_reg;
        was_next      = was_reg;
        flags_next    = flags_reg;
        top_word_next = top_word_reg;
        top_bit_next  = top_bit_reg;
        any_next      = any_reg;
        done_next     = 1'b0;
        was_out_next  = was_out_reg;
        oor_out_next  = oor_out_reg;
        high_next     = high_reg;
        any_out_next  = any_out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    idx_next   = bit_index;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                q_next     = div_prod[PROD_W-1:bmsc_pkg::RECIP_SHIFT];
                oor_next   = 17'(idx_reg) >= 17'(CAPACITY);
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                word_next  = q_reg[AW-1:0];
                off_next   = rem_full[OW-1:0];
                was_next   = 1'b0;
                state_next = oor_reg ? S_OUT : S_RMW;
            end
            S_RMW:
            begin
                was_next             = cur_word[off_reg];
                flags_next[word_reg] = |new_word;
                state_next           = S_OUT;
                if (op_reg == bmsc_pkg::OP_SET)
                begin
                    any_next = 1'b1;
                    if (!any_reg || (word_reg > top_word_reg))
                    begin
                        top_word_next = word_reg;
                        top_bit_next  = new_msb;
                    end
                    else if (word_reg == top_word_reg)
                    begin
                        top_bit_next = new_msb;
                    end
                end
                else if ((op_reg == bmsc_pkg::OP_CLEAR) && any_reg &&
                         (word_reg == top_word_reg))
                begin
                    if (|new_word)
                    begin
                        top_bit_next = new_msb;
                    end
                    else
                    begin
                        state_next = S_SRCH_A;
                    end
                end
            end
            S_SRCH_A:
            begin
                state_next = S_SRCH_B;
            end
            S_SRCH_B:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                if (search.found)
                begin
                    top_word_next = search.word[AW-1:0];
                    state_next    = S_MSB;
                end
                else
                begin
                    any_next      = 1'b0;
                    top_word_next = '0;
                    top_bit_next  = '0;
                    state_next    = S_OUT;
                end
            end
            S_MSB:
            begin
                top_bit_next = rd_msb;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                done_next    = 1'b1;
                was_out_next = was_reg;
                oor_out_next = oor_reg;
                any_out_next = any_reg;
                high_next    = any_reg ? high_full[bmsc_pkg::HIGH_W-1:0] : '0;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= bmsc_pkg::OP_TEST;
            idx_reg      <= '0;
            q_reg        <= '0;
            oor_reg      <= 1'b0;
            word_reg     <= '0;
            off_reg      <= '0;
            was_reg      <= 1'b0;
            flags_reg    <= '0;
            top_word_reg <= '0;
            top_bit_reg  <= '0;
            any_reg      <= 1'b0;
            done_reg     <= 1'b0;
            was_out_reg  <= 1'b0;
            oor_out_reg  <= 1'b0;
            high_reg     <= '0;
            any_out_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            idx_reg      <= idx_next;
            q_reg        <= q_next;
            oor_reg      <= oor_next;
            word_reg     <= word_next;
            off_reg      <= off_next;
            was_reg      <= was_next;
            flags_reg    <= flags_next;
            top_word_reg <= top_word_next;
            top_bit_reg  <= top_bit_next;
            any_reg      <= any_next;
            done_reg     <= done_next;
            was_out_reg  <= was_out_next;
            oor_out_reg  <= oor_out_next;
            high_reg     <= high_next;
            any_out_reg  <= any_out_next;
        end
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign bit_was_set       = was_out_reg;
    assign out_of_range      = oor_out_reg;
    assign highest_set_index = high_reg;
    assign any_set           = any_out_reg;

endmodule

[sv/bmsc_checker.sv]
// Port-level checks for the bitmap block and their binding to the top level.
module bmsc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic                            bit_was_set,
    input logic                            out_of_range,
    input logic [bmsc_pkg::HIGH_W-1:0]     highest_set_index,
    input logic                            any_set
);

    // A result transfer leaves the block ready for the next command
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done asserted while busy");

    // An accepted command keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted command did not make the block busy");

    // Out-of-range access never reports a set bit
    a_oor_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_range) |-> !bit_was_set)
        else $error("out-of-range result reports a set bit");

    // An empty store reports index zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !any_set) |-> (highest_set_index == '0))
        else $error("empty store reports a nonzero highest index");

    // A bit seen as set means the store is not empty or the index was in range
    a_was_any: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bit_was_set) |-> (any_set || !out_of_range))
        else $error("set bit reported with inconsistent status");

endmodule

bind bitmap_set_clear_test_msb bmsc_checker u_bmsc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .done              (done),
    .bit_was_set       (bit_was_set),
    .out_of_range      (out_of_range),
    .highest_set_index (highest_set_index),
    .any_set           (any_set)
);
